>>> sv/margin_violation_ranker_defines.svh
// Assertion macros for the margin violation ranker.
// Included by the top level; empty bodies under SYNTHESIS.
`ifndef MARGIN_VIOLATION_RANKER_DEFINES_SVH
`define MARGIN_VIOLATION_RANKER_DEFINES_SVH
`ifndef SYNTHESIS
`define MVR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MVR_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define MVR_ASSERT(label, clk, rst_n, prop)
`define MVR_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> sv/mvr_pkg.sv
// Shared types and constants of the margin violation ranker.
// No dependencies.
`default_nettype none
package mvr_pkg;
    localparam int NumTypes  = 128;
    localparam int MaxDims   = 128;
    localparam int ValueBits = 16;
    localparam int FracBits  = ValueBits - 3;
    localparam int TypeBits  = $clog2(NumTypes);
    localparam int DimBits   = $clog2(MaxDims);
    localparam int AccBits   = 48;
    localparam int ProdBits  = 2 * ValueBits;

    localparam logic [2:0] CMD_LOAD_QUERY  = 3'd0;
    localparam logic [2:0] CMD_LOAD_EMBED  = 3'd1;
    localparam logic [2:0] CMD_LOAD_MARGIN = 3'd2;
    localparam logic [2:0] CMD_START       = 3'd3;
    localparam logic [2:0] CMD_CANDIDATE   = 3'd4;

    localparam logic [7:0] REG_EMBED_SIZE = 8'd0;
    localparam logic [7:0] REG_USE_MARGIN = 8'd1;

    typedef struct packed {
        logic load_q;      // write query word
        logic load_e;      // write embedding word
        logic load_m;      // write margin word
        logic clear;       // clear accumulator, latch item
        logic mac;         // issue one dimension
        logic finish;      // commit score (positive or candidate)
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_empty;  // no MAC in flight
    } dp_sts_t;
endpackage
`default_nettype wire

>>> sv/margin_violation_ranker.sv
// Top level of the margin violation ranker.
// Depends on mvr_pkg, mvr_ctrl, mvr_datapath and the defines header.
`default_nettype none
`include "margin_violation_ranker_defines.svh"
// Load words are written as they are taken. A start or candidate word runs one dot
// product through a single shared multiply-accumulate unit, one dimension per cycle;
// no further word is taken until the dot product has finished and its results are
// in the output register. Results leave through that output register; words are
// taken while a result waits there, and a second result holds the block until the
// receiver frees the register.
module margin_violation_ranker
    import mvr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[2:0], type_index[9:3], other_index[16:10], dim_index[23:17],
    // value[39:24]
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // type_out[6:0], pad
    output logic             m_axis_tuser,   // is_best
    output logic             m_axis_tlast,   // last_of_run
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic is_cand, reset_first, violate;
    logic [DimBits-1:0] mac_dim;
    logic [TypeBits-1:0] best_type, out_type, cur_type;
    logic [7:0] dim_count_reg;
    logic use_margin_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg  <= 8'd128;
            use_margin_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_EMBED_SIZE)
                dim_count_reg <= cfg_data;
            else if (cfg_index == REG_USE_MARGIN)
                use_margin_reg <= cfg_data[0];
        end
    end

    mvr_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .command(s_axis_tdata[2:0]), .last(s_axis_tlast),
        .dim_count(dim_count_reg), .cmd, .sts, .is_cand, .reset_first, .mac_dim,
        .violate, .best_type, .cand_type(cur_type),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_type, .out_best(m_axis_tuser), .out_last(m_axis_tlast)
    );

    mvr_datapath u_dp (
        .clk, .rst_n, .cmd, .sts, .is_cand,
        .type_index(s_axis_tdata[9:3]), .other_index(s_axis_tdata[16:10]),
        .dim_index(s_axis_tdata[23:17]), .value(s_axis_tdata[39:24]),
        .mac_dim, .use_margin(use_margin_reg), .reset_first, .violate, .best_type,
        .cur_type
    );

    assign m_axis_tdata = {1'b0, out_type};

    `MVR_ASSERT(a_best_is_last, clk, rst_n, (m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast)))
    `MVR_NEVER(a_pad_zero, clk, rst_n, (m_axis_tvalid && m_axis_tdata[7]))
    `MVR_ASSERT(a_valid_hold, clk, rst_n, ((m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid))
    `MVR_ASSERT(a_out_hold, clk, rst_n, ((m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)))
endmodule
`default_nettype wire

>>> sv/mvr_datapath.sv
// Datapath: memories, shared MAC, score compare and best tracking.
// Depends on mvr_pkg.
`default_nettype none
module mvr_datapath
    import mvr_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dp_cmd_t                     cmd,
    output dp_sts_t                          sts,
    input  wire logic                        is_cand,
    input  wire logic [TypeBits-1:0]         type_index,
    input  wire logic [TypeBits-1:0]         other_index,
    input  wire logic [DimBits-1:0]          dim_index,
    input  wire logic signed [ValueBits-1:0] value,
    input  wire logic [DimBits-1:0]          mac_dim,
    input  wire logic                        use_margin,
    input  wire logic                        reset_first,
    output logic                             violate,
    output logic [TypeBits-1:0]              best_type,
    output logic [TypeBits-1:0]              cur_type
);
    logic signed [ValueBits-1:0] query_mem [MaxDims];
    logic signed [ValueBits-1:0] embed_mem [NumTypes*MaxDims];
    logic signed [ValueBits-1:0] margin_mem [NumTypes*NumTypes];

    logic [TypeBits-1:0] item_type_reg;
    logic signed [ValueBits-1:0] q_rd_reg, e_rd_reg, m_rd_reg;
    logic rd_valid_reg, prod_valid_reg;
    logic signed [ProdBits-1:0] prod_reg;
    logic signed [AccBits-1:0] acc_reg;
    logic signed [AccBits-1:0] pos_score_reg, best_score_reg;
    logic [TypeBits-1:0] pos_type_reg, best_type_reg;
    logic first_reg;

    logic signed [AccBits:0] sum_wide;
    logic signed [AccBits-1:0] acc_next;
    logic signed [AccBits:0] diff, margin;

    localparam logic signed [AccBits:0] AccMax = {2'b00, {(AccBits-1){1'b1}}};
    localparam logic signed [AccBits:0] AccMin = {2'b11, {(AccBits-1){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
            query_mem[dim_index] <= value;
        if (cmd.load_e)
            embed_mem[{type_index, dim_index}] <= value;
        if (cmd.load_m)
            margin_mem[{type_index, other_index}] <= value;
        q_rd_reg <= query_mem[mac_dim];
        e_rd_reg <= embed_mem[{item_type_reg, mac_dim}];
        m_rd_reg <= margin_mem[{pos_type_reg, item_type_reg}];
        prod_reg <= q_rd_reg * e_rd_reg;
    end

    always_comb
    begin
        sum_wide = {acc_reg[AccBits-1], acc_reg}
                   + {{(AccBits+1-ProdBits){prod_reg[ProdBits-1]}}, prod_reg};
        if (sum_wide > AccMax)
            acc_next = AccMax[AccBits-1:0];
        else if (sum_wide < AccMin)
            acc_next = AccMin[AccBits-1:0];
        else
            acc_next = sum_wide[AccBits-1:0];
        diff = {pos_score_reg[AccBits-1], pos_score_reg} - {acc_reg[AccBits-1], acc_reg};
        if (use_margin)
            margin = {{(AccBits+1-ValueBits-FracBits){m_rd_reg[ValueBits-1]}}, m_rd_reg,
                      {FracBits{1'b0}}};
        else
            margin = (AccBits+1)'(1) <<< (2 * FracBits);
        violate = diff < margin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
            item_type_reg  <= '0;
            pos_score_reg  <= '0;
            pos_type_reg   <= '0;
            best_score_reg <= '0;
            best_type_reg  <= '0;
            first_reg      <= 1'b1;
        end
        else
        begin
            rd_valid_reg   <= cmd.mac;
            prod_valid_reg <= rd_valid_reg;
            if (cmd.clear)
            begin
                acc_reg       <= '0;
                item_type_reg <= type_index;
            end
            else if (prod_valid_reg)
                acc_reg <= acc_next;
            if (cmd.finish)
            begin
                if (!is_cand)
                begin
                    pos_score_reg <= acc_reg;
                    pos_type_reg  <= item_type_reg;
                    first_reg     <= 1'b1;
                end
                else
                begin
                    if (first_reg || acc_reg > best_score_reg)
                    begin
                        best_score_reg <= acc_reg;
                        best_type_reg  <= item_type_reg;
                    end
                    first_reg <= reset_first;
                end
            end
        end
    end

    always_comb
    begin
        sts.pipe_empty = !rd_valid_reg && !prod_valid_reg && !cmd.mac;
        best_type = (first_reg || acc_reg > best_score_reg) ? item_type_reg : best_type_reg;
        cur_type = item_type_reg;
    end
endmodule
`default_nettype wire

>>> sv/mvr_ctrl.sv
// Controller: accepts words, sequences the dot product, emits results.
// Depends on mvr_pkg.
`default_nettype none
module mvr_ctrl
    import mvr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          command,
    input  wire logic                last,
    input  wire logic [7:0]          dim_count,
    output dp_cmd_t                  cmd,
    input  wire dp_sts_t             sts,
    output logic                     is_cand,
    output logic                     reset_first,
    output logic [DimBits-1:0]       mac_dim,
    input  wire logic                violate,
    input  wire logic [TypeBits-1:0] best_type,
    input  wire logic [TypeBits-1:0] cand_type,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [TypeBits-1:0]      out_type,
    output logic                     out_best,
    output logic                     out_last
);
    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_VIOL, S_BEST} state_t;

    state_t state_reg, state_next;
    logic [DimBits:0] cnt_reg, cnt_next, n_dims;
    logic cand_reg, cand_next, last_reg, last_next;
    logic ov_reg, ov_next;
    logic [TypeBits-1:0] ot_reg, ot_next, bt_reg, bt_next;
    logic ob_reg, ob_next, ol_reg, ol_next;
    logic accept, take;

    assign n_dims = (dim_count > 8'(MaxDims)) ? (DimBits+1)'(MaxDims)
                                               : dim_count[DimBits:0];
    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign take = ov_reg && out_ready;
    assign mac_dim = cnt_reg[DimBits-1:0];
    assign is_cand = cand_reg;
    assign reset_first = last_reg;
    assign out_valid = ov_reg;
    assign out_type = ot_reg;
    assign out_best = ob_reg;
    assign out_last = ol_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cand_next = cand_reg;
        last_next = last_reg;
        ov_next = take ? 1'b0 : ov_reg;
        ot_next = ot_reg;
        ob_next = ob_reg;
        ol_next = ol_reg;
        bt_next = bt_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_LOAD_QUERY:  cmd.load_q = 1'b1;
                        CMD_LOAD_EMBED:  cmd.load_e = 1'b1;
                        CMD_LOAD_MARGIN: cmd.load_m = 1'b1;
                        CMD_START, CMD_CANDIDATE:
                        begin
                            cmd.clear = 1'b1;
                            cand_next = (command == CMD_CANDIDATE);
                            last_next = last;
                            cnt_next = '0;
                            state_next = S_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAC:
            begin
                if (cnt_reg < n_dims)
                begin
                    cmd.mac = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    cmd.finish = 1'b1;
                    bt_next = best_type;
                    if (!cand_reg)
                        state_next = S_IDLE;
                    else if (violate)
                        state_next = S_VIOL;
                    else if (last_reg)
                        state_next = S_BEST;
                    else
                        state_next = S_IDLE;
                end
            end
            S_VIOL:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    ot_next = cand_type;
                    ob_next = 1'b0;
                    ol_next = 1'b0;
                    state_next = last_reg ? S_BEST : S_IDLE;
                end
            end
            S_BEST:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    ot_next = bt_reg;
                    ob_next = 1'b1;
                    ol_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            cand_reg <= 1'b0;
            last_reg <= 1'b0;
            ov_reg <= 1'b0;
            ot_reg <= '0;
            ob_reg <= 1'b0;
            ol_reg <= 1'b0;
            bt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            cand_reg <= cand_next;
            last_reg <= last_next;
            ov_reg <= ov_next;
            ot_reg <= ot_next;
            ob_reg <= ob_next;
            ol_reg <= ol_next;
            bt_reg <= bt_next;
        end
    end
endmodule
`default_nettype wire

>>> bench/margin_violation_ranker_tb.sv
// Self-checking bench for margin_violation_ranker: loads tables, runs positive/candidate
// sets under several embed sizes and margin modes, and checks every result word.
// Depends on mvr_pkg and the margin_violation_ranker RTL.
`timescale 1ns / 100ps
module margin_violation_ranker_tb;
    import mvr_pkg::*;

    typedef struct packed {
        logic signed [15:0] value;
        logic [6:0]         dim;
        logic [6:0]         other;
        logic [6:0]         kind;
        logic [2:0]         cmd;
    } cmd_word_t;

    typedef struct {
        cmd_word_t w;
        logic      last;
    } cmd_item_t;

    typedef struct {
        logic [6:0] type_out;
        logic       is_best;
        logic       last_of_run;
    } rank_res_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    margin_violation_ranker dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic signed [15:0] query_mem [MaxDims];
    logic signed [15:0] embed_mem [NumTypes*MaxDims];
    logic signed [15:0] margin_mem [NumTypes*NumTypes];
    logic [6:0] pos_type = '0;
    longint     pos_score = 0;
    longint     best_score = 0;
    logic [6:0] best_type = '0;
    logic       set_open = 1;
    logic [7:0] dim_count = 8'd128;
    logic       use_margin = 1;

    cmd_item_t pend_q[$];
    rank_res_t rank_q[$];

    int  tx_idle = 0;
    int  rx_idle = 0;
    logic in_fire = 0;
    logic stall_go = 0;
    logic stall_done = 0;
    int  stall_cnt = 0;
    int  errors = 0;
    int  cycles = 0;
    int  words_in = 0;
    int  n_viol = 0;
    int  n_best = 0;

    // generator state
    int  pool[8] = '{0, 1, 42, 63, 64, 85, 126, 127};
    int  gen_eff = 128;

    function automatic longint dot_score(input logic [6:0] t);
        int n;
        longint acc;
        longint amax;
        amax = (longint'(1) << 47) - 1;
        n = (dim_count > MaxDims) ? MaxDims : dim_count;
        acc = 0;
        for (int d = 0; d < n; d++)
        begin
            acc += longint'(query_mem[d]) * longint'(embed_mem[t*MaxDims + d]);
            if (acc > amax) acc = amax;
            if (acc < -amax - 1) acc = -amax - 1;
        end
        return acc;
    endfunction

    function automatic void predict_word(input cmd_item_t it);
        longint s;
        longint mg;
        rank_res_t r;
        case (it.w.cmd)
            CMD_LOAD_QUERY:  query_mem[it.w.dim] = it.w.value;
            CMD_LOAD_EMBED:  embed_mem[it.w.kind*MaxDims + it.w.dim] = it.w.value;
            CMD_LOAD_MARGIN: margin_mem[it.w.kind*NumTypes + it.w.other] = it.w.value;
            CMD_START:
            begin
                pos_type = it.w.kind;
                pos_score = dot_score(it.w.kind);
                set_open = 1;
            end
            CMD_CANDIDATE:
            begin
                s = dot_score(it.w.kind);
                if (use_margin)
                    mg = longint'(margin_mem[pos_type*NumTypes + it.w.kind]) <<< FracBits;
                else
                    mg = longint'(1) << (2*FracBits);
                if (pos_score - s < mg)
                begin
                    r.type_out = it.w.kind;
                    r.is_best = 0;
                    r.last_of_run = 0;
                    rank_q.insert(rank_q.size(), r);
                end
                if (set_open || s > best_score)
                begin
                    best_score = s;
                    best_type = it.w.kind;
                end
                set_open = 0;
                if (it.last)
                begin
                    r.type_out = best_type;
                    r.is_best = 1;
                    r.last_of_run = 1;
                    rank_q.insert(rank_q.size(), r);
                    set_open = 1;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        rank_res_t e;
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("%0t timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_item_t it;
            it.w = s_axis_tdata;
            it.last = s_axis_tlast;
            predict_word(it);
            words_in++;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (rank_q.size() == 0)
            begin
                $display("%0t unexpected word: exp none, got type %0d best %0b last %0b",
                         $time, m_axis_tdata[6:0], m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                e = rank_q.pop_front();
                if (e.is_best) n_best++; else n_viol++;
                if (m_axis_tdata[6:0] !== e.type_out)
                begin
                    $display("%0t type_out: exp %0d got %0d", $time, e.type_out,
                             m_axis_tdata[6:0]);
                    errors++;
                end
                if (m_axis_tuser !== e.is_best)
                begin
                    $display("%0t is_best: exp %0b got %0b", $time, e.is_best, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== e.last_of_run)
                begin
                    $display("%0t last_of_run: exp %0b got %0b", $time, e.last_of_run,
                             m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        cmd_item_t it;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle)
            begin
                it = pend_q.pop_front();
                s_axis_tdata <= it.w;
                s_axis_tlast <= it.last;
                s_axis_tvalid <= 1;
            end
            else
                s_axis_tvalid <= 0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_go && !stall_done)
            m_axis_tready <= 0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if (stall_go && !stall_done)
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= 600)
                stall_done <= 1;
        end
    end

    task automatic put(input logic [2:0] c, input int t, input int o, input int d,
                       input int v, input logic lst);
        cmd_item_t it;
        it.w.cmd = c;
        it.w.kind = t[6:0];
        it.w.other = o[6:0];
        it.w.dim = d[6:0];
        it.w.value = v[15:0];
        it.last = lst;
        pend_q.insert(pend_q.size(), it);
    endtask

    function automatic int rand_val();
        int r;
        r = $urandom_range(7);
        if (r == 0) return ($urandom_range(1)) ? 32767 : -32768;
        if (r < 4) return $signed($urandom_range(4096)) - 2048;
        return $signed($urandom_range(65535)) - 32768;
    endfunction

    function automatic bit eligible(input int t);
        return gen_eff <= 16 || t == 0 || t == 127;
    endfunction

    function automatic int pick_type();
        int t;
        do t = pool[$urandom_range(7)]; while (!eligible(t));
        return t;
    endfunction

    task automatic gen_random(input int n);
        int r;
        int t;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                put(CMD_CANDIDATE, pick_type(), $urandom_range(127), $urandom_range(127),
                    rand_val(), $urandom_range(3) == 0);
            else if (r < 65)
                put(CMD_START, pick_type(), $urandom_range(127), $urandom_range(127),
                    rand_val(), $urandom_range(1));
            else if (r < 72)
                put(CMD_LOAD_QUERY, $urandom_range(127), $urandom_range(127),
                    $urandom_range(127), rand_val(), $urandom_range(1));
            else if (r < 80)
            begin
                t = $urandom_range(1) ? pool[$urandom_range(7)] : $urandom_range(127);
                put(CMD_LOAD_EMBED, t, $urandom_range(127), $urandom_range(127),
                    rand_val(), $urandom_range(1));
            end
            else if (r < 92)
            begin
                if ($urandom_range(3) != 0)
                    put(CMD_LOAD_MARGIN, pool[$urandom_range(7)], pool[$urandom_range(7)],
                        $urandom_range(127), rand_val(), $urandom_range(1));
                else
                    put(CMD_LOAD_MARGIN, $urandom_range(127), $urandom_range(127),
                        $urandom_range(127), rand_val(), $urandom_range(1));
            end
            else
                put(CMD_CANDIDATE + 3'($urandom_range(1, 3)), $urandom_range(127),
                    $urandom_range(127), $urandom_range(127), rand_val(), $urandom_range(1));
        end
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_axis_tvalid || rank_q.size() > 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_EMBED_SIZE) dim_count = val;
        else if (idx == REG_USE_MARGIN) use_margin = val[0];
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_mode(input int es, input int mode);
        write_reg(REG_EMBED_SIZE, es[7:0]);
        write_reg(REG_USE_MARGIN, mode[7:0]);
        gen_eff = (es > MaxDims) ? MaxDims : es;
    endtask

    int phase_es[8]   = '{16, 1, 0, 255, 128, 5, 16, 9};
    int phase_mode[8] = '{1, 0, 1, 0, 1, 0, 0, 1};
    int phase_n[8]    = '{30, 20, 10, 10, 10, 30, 15, 15};

    initial
    begin
        int fill_n;
        tx_idle = 38;
        rx_idle = 46;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        set_mode(16, 1);

        // table fill: full query, full rows for 0/127, 16 dims elsewhere, all pool margins
        for (int d = 0; d < MaxDims; d++)
            put(CMD_LOAD_QUERY, 0, 0, d, rand_val(), 0);
        for (int d = 0; d < MaxDims; d++)
        begin
            put(CMD_LOAD_EMBED, 0, 0, d, rand_val(), 0);
            put(CMD_LOAD_EMBED, 127, 0, d, rand_val(), 0);
        end
        for (int p = 1; p < 7; p++)
            for (int d = 0; d < 16; d++)
                if (pool[p] != 64)
                    put(CMD_LOAD_EMBED, pool[p], 0, d, rand_val(), 0);
        // row 64 mirrors row 63 for a tie
        fill_n = pend_q.size();
        for (int i = 0; i < fill_n; i++)
            if (pend_q[i].w.cmd == CMD_LOAD_EMBED && pend_q[i].w.kind == 7'd63)
                put(CMD_LOAD_EMBED, 64, 0, pend_q[i].w.dim, pend_q[i].w.value, 0);
        for (int a = 0; a < 8; a++)
            for (int b = 0; b < 8; b++)
                put(CMD_LOAD_MARGIN, pool[a], pool[b], 0, rand_val(), 0);

        // directed
        put(CMD_CANDIDATE, 1, 0, 0, 0, 0);
        put(CMD_CANDIDATE, 42, 0, 0, 0, 1);
        put(CMD_CANDIDATE + 3'd1, 127, 127, 127, -1, 1);
        put(CMD_CANDIDATE + 3'd2, 127, 127, 127, -1, 1);
        put(CMD_CANDIDATE + 3'd3, 127, 127, 127, -1, 1);
        put(CMD_START, 63, 0, 0, 0, 0);
        put(CMD_CANDIDATE, 63, 0, 0, 0, 0);
        put(CMD_CANDIDATE, 64, 0, 0, 0, 1);
        put(CMD_START, 127, 0, 0, 0, 0);
        put(CMD_LOAD_MARGIN, 127, 127, 0, -32768, 0);
        put(CMD_CANDIDATE, 127, 0, 0, 0, 1);
        put(CMD_LOAD_MARGIN, 127, 127, 0, 32767, 0);
        put(CMD_CANDIDATE, 127, 127, 127, 0, 1);
        put(CMD_CANDIDATE, 0, 0, 0, 0, 1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            tx_idle = (ph < 3) ? 38 : (ph < 6) ? 46 : 0;
            rx_idle = (ph < 3) ? 46 : (ph < 6) ? 38 : 0;
            set_mode(phase_es[ph], phase_mode[ph]);
            gen_random(phase_n[ph]);
            if (ph == 5)
                stall_go = 1;
            drain();
        end

        $display("%0d words in, %0d violations and %0d best results checked", words_in,
                 n_viol, n_best);
        $display("dimension counts 0..255 and both margin modes, with a long output stall");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
